>>> sv/ipv4bf_pkg.sv
// Package for the IPv4 blacklist packet filter.
// Holds the beat and job types, table sizing, protocol constants and result codes.
// No dependencies.
package ipv4bf_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int NUM_TABLES = 6;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [5:0] MAC_ADDR_BYTES = 6'd6;

    localparam logic [3:0] RSN_SHORT_ETH = 4'd0;
    localparam logic [3:0] RSN_NOT_IPV4 = 4'd1;
    localparam logic [3:0] RSN_SHORT_IP = 4'd2;
    localparam logic [3:0] RSN_TRUNC_L4 = 4'd3;
    localparam logic [3:0] RSN_HIT_BASE = 4'd4;
    localparam logic [3:0] RSN_NONE = 4'd10;

    localparam logic [1:0] UPD_DONE = 2'd0;
    localparam logic [1:0] UPD_FULL = 2'd1;
    localparam logic [1:0] UPD_NOT_FOUND = 2'd2;

    localparam logic [2:0] TBL_TUPLE = 3'd0;
    localparam logic [2:0] TBL_PAIR = 3'd1;
    localparam logic [2:0] TBL_SRC_IP = 3'd2;
    localparam logic [2:0] TBL_DST_IP = 3'd3;
    localparam logic [2:0] TBL_PORT = 3'd4;
    localparam logic [2:0] TBL_MAC = 3'd5;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [2:0]  table_select;
        logic [31:0] key_source_ip;
        logic [31:0] key_destination_ip;
        logic [15:0] key_port;
        logic [47:0] key_mac;
        logic        remove;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic        drop;
        logic [3:0]  reason;
        logic [1:0]  update_status;
    } result_t;

    typedef struct packed {
        logic        is_update;
        logic [2:0]  tsel;
        logic        remove;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] port;
        logic [47:0] mac;
        logic        early;
        logic        early_drop;
        logic [3:0]  early_reason;
        logic [1:0]  early_status;
    } job_t;

endpackage

>>> sv/ipv4bf_queue.sv
// Two-entry job queue between the front and back parts of the filter.
// Depends on ipv4bf_pkg for the job type.
module ipv4bf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipv4bf_pkg::job_t  wdata,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output ipv4bf_pkg::job_t  rdata
);
    import ipv4bf_pkg::*;

    job_t       slot_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = slot_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

>>> sv/ipv4bf_front.sv
// Front part of the filter: captures frame fields byte by byte and classifies frames.
// Emits one job per table update or per final frame byte. Depends on ipv4bf_pkg and
// ipv4bf_len_sat.
module ipv4bf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ipv4bf_pkg::in_item_t  item,
    output logic                  job_push,
    output ipv4bf_pkg::job_t      job
);
    import ipv4bf_pkg::*;

    logic [5:0]  bytes_seen_reg;
    logic [47:0] mac_reg;
    logic [15:0] ethertype_reg;
    logic [7:0]  protocol_reg;
    logic [31:0] sip_reg;
    logic [31:0] dip_reg;
    logic [15:0] port_reg;

    logic [47:0] mac_next;
    logic [15:0] ethertype_next;
    logic [7:0]  protocol_next;
    logic [31:0] sip_next;
    logic [31:0] dip_next;
    logic [15:0] port_next;
    logic [5:0]  len;
    logic        byte_beat;

    assign byte_beat = accept && (item.kind == KIND_FRAME);

    ipv4bf_len_sat u_len_sat (
        .idx (bytes_seen_reg),
        .len (len)
    );

    always_comb
    begin
        mac_next = mac_reg;
        ethertype_next = ethertype_reg;
        protocol_next = protocol_reg;
        sip_next = sip_reg;
        dip_next = dip_reg;
        port_next = port_reg;
        if (bytes_seen_reg >= MAC_ADDR_BYTES && bytes_seen_reg < 6'd12)
        begin
            mac_next = {mac_reg[39:0], item.data_byte};
        end
        else if (bytes_seen_reg == 6'd12 || bytes_seen_reg == 6'd13)
        begin
            ethertype_next = {ethertype_reg[7:0], item.data_byte};
        end
        else if (bytes_seen_reg == 6'd23)
        begin
            protocol_next = item.data_byte;
        end
        else if (bytes_seen_reg >= 6'd26 && bytes_seen_reg <= 6'd29)
        begin
            sip_next = {sip_reg[23:0], item.data_byte};
        end
        else if (bytes_seen_reg >= 6'd30 && bytes_seen_reg <= 6'd33)
        begin
            dip_next = {dip_reg[23:0], item.data_byte};
        end
        else if (bytes_seen_reg == 6'd36 || bytes_seen_reg == 6'd37)
        begin
            port_next = {port_reg[7:0], item.data_byte};
        end
    end

    always_comb
    begin
        job = '0;
        job_push = accept && (item.kind == KIND_UPDATE || item.last);
        if (item.kind == KIND_UPDATE)
        begin
            job.is_update = 1'b1;
            job.tsel = item.table_select;
            job.remove = item.remove;
            job.sip = item.key_source_ip;
            job.dip = item.key_destination_ip;
            job.port = item.key_port;
            job.mac = item.key_mac;
            job.early = (item.table_select > TBL_MAC);
            job.early_status = UPD_NOT_FOUND;
        end
        else
        begin
            job.sip = sip_next;
            job.dip = dip_next;
            job.mac = mac_next;
            job.port = (protocol_next == PROTO_TCP || protocol_next == PROTO_UDP)
                       ? port_next : 16'd0;
            job.early = 1'b1;
            priority if (len < 6'd14)
            begin
                job.early_reason = RSN_SHORT_ETH;
            end
            else if (ethertype_next != ETHERTYPE_IPV4)
            begin
                job.early_reason = RSN_NOT_IPV4;
            end
            else if (len < 6'd34)
            begin
                job.early_reason = RSN_SHORT_IP;
            end
            else if ((protocol_next == PROTO_TCP && len < 6'd54)
                     || (protocol_next == PROTO_UDP && len < 6'd42))
            begin
                job.early_drop = 1'b1;
                job.early_reason = RSN_TRUNC_L4;
            end
            else
            begin
                job.early = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= 6'd0;
            mac_reg <= '0;
            ethertype_reg <= '0;
            protocol_reg <= '0;
            sip_reg <= '0;
            dip_reg <= '0;
            port_reg <= '0;
        end
        else if (byte_beat)
        begin
            bytes_seen_reg <= item.last ? 6'd0 : len;
            mac_reg <= mac_next;
            ethertype_reg <= ethertype_next;
            protocol_reg <= protocol_next;
            sip_reg <= sip_next;
            dip_reg <= dip_next;
            port_reg <= port_next;
        end
    end
endmodule

>>> sv/ipv4bf_back.sv
// Back part of the filter: scans the six blacklist tables slot by slot for each job not settled early.
// Holds the key memories, the valid bits and the result register. Depends on ipv4bf_pkg.
module ipv4bf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  ipv4bf_pkg::job_t     q_job,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output ipv4bf_pkg::result_t  result
);
    import ipv4bf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

    logic [79:0] tuple_mem [TABLE_ENTRIES];
    logic [63:0] pair_mem [TABLE_ENTRIES];
    logic [31:0] sip_mem [TABLE_ENTRIES];
    logic [31:0] dip_mem [TABLE_ENTRIES];
    logic [15:0] port_mem [TABLE_ENTRIES];
    logic [47:0] mac_mem [TABLE_ENTRIES];

    logic [79:0] tuple_rd_reg;
    logic [63:0] pair_rd_reg;
    logic [31:0] sip_rd_reg;
    logic [31:0] dip_rd_reg;
    logic [15:0] port_rd_reg;
    logic [47:0] mac_rd_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg [NUM_TABLES];
    logic [1:0]               state_reg;
    job_t                     job_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [SLOT_W-1:0]        cmp_idx_reg;
    logic                     cmp_en_reg;
    logic [NUM_TABLES-1:0]    hits_reg;
    logic                     found_reg;
    logic [SLOT_W-1:0]        found_idx_reg;
    logic                     free_reg;
    logic [SLOT_W-1:0]        free_idx_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic [NUM_TABLES-1:0]    hits;
    logic [TABLE_ENTRIES-1:0] sel_row;
    logic                     out_free;
    logic                     finish;
    logic                     mem_wr;
    result_t                  res_next;

    assign empty = !out_valid_reg;
    assign result = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign q_pop = (state_reg == S_IDLE) && !q_empty;
    assign finish = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        sel_row = '0;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            if (job_reg.tsel == 3'(t))
            begin
                sel_row = valid_reg[t];
            end
        end
    end

    always_comb
    begin
        hits[0] = valid_reg[0][cmp_idx_reg]
                  && tuple_rd_reg == {job_reg.sip, job_reg.dip, job_reg.port};
        hits[1] = valid_reg[1][cmp_idx_reg] && pair_rd_reg == {job_reg.sip, job_reg.dip};
        hits[2] = valid_reg[2][cmp_idx_reg] && sip_rd_reg == job_reg.sip;
        hits[3] = valid_reg[3][cmp_idx_reg] && dip_rd_reg == job_reg.dip;
        hits[4] = valid_reg[4][cmp_idx_reg] && port_rd_reg == job_reg.port;
        hits[5] = valid_reg[5][cmp_idx_reg] && mac_rd_reg == job_reg.mac;
    end

    always_comb
    begin
        res_next = '0;
        mem_wr = 1'b0;
        res_next.result_kind = job_reg.is_update;
        if (job_reg.early)
        begin
            res_next.drop = job_reg.early_drop;
            res_next.reason = job_reg.early_reason;
            res_next.update_status = job_reg.early_status;
        end
        else if (job_reg.is_update)
        begin
            priority if (job_reg.remove)
            begin
                res_next.update_status = found_reg ? UPD_DONE : UPD_NOT_FOUND;
            end
            else if (found_reg)
            begin
                res_next.update_status = UPD_DONE;
            end
            else if (free_reg)
            begin
                res_next.update_status = UPD_DONE;
                mem_wr = 1'b1;
            end
            else
            begin
                res_next.update_status = UPD_FULL;
            end
        end
        else
        begin
            res_next.drop = |hits_reg;
            res_next.reason = RSN_NONE;
            for (int t = NUM_TABLES - 1; t >= 0; t--)
            begin
                if (hits_reg[t])
                begin
                    res_next.reason = RSN_HIT_BASE + 4'(t);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tuple_rd_reg <= tuple_mem[idx_reg];
        pair_rd_reg <= pair_mem[idx_reg];
        sip_rd_reg <= sip_mem[idx_reg];
        dip_rd_reg <= dip_mem[idx_reg];
        port_rd_reg <= port_mem[idx_reg];
        mac_rd_reg <= mac_mem[idx_reg];
        if (finish && mem_wr)
        begin
            unique case (job_reg.tsel)
                TBL_TUPLE:  tuple_mem[free_idx_reg] <= {job_reg.sip, job_reg.dip, job_reg.port};
                TBL_PAIR:   pair_mem[free_idx_reg] <= {job_reg.sip, job_reg.dip};
                TBL_SRC_IP: sip_mem[free_idx_reg] <= job_reg.sip;
                TBL_DST_IP: dip_mem[free_idx_reg] <= job_reg.dip;
                TBL_PORT:   port_mem[free_idx_reg] <= job_reg.port;
                default:    mac_mem[free_idx_reg] <= job_reg.mac;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        cmp_idx_reg <= idx_reg;
        if (finish)
        begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            cmp_en_reg <= 1'b0;
            hits_reg <= '0;
            found_reg <= 1'b0;
            found_idx_reg <= '0;
            free_reg <= 1'b0;
            free_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                valid_reg[t] <= '0;
            end
        end
        else
        begin
            cmp_en_reg <= (state_reg == S_SCAN);
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmp_en_reg)
            begin
                hits_reg <= hits_reg | hits;
                if (hits[job_reg.tsel] && !found_reg)
                begin
                    found_reg <= 1'b1;
                    found_idx_reg <= cmp_idx_reg;
                end
                if (!sel_row[cmp_idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        idx_reg <= '0;
                        hits_reg <= '0;
                        found_reg <= 1'b0;
                        free_reg <= 1'b0;
                        state_reg <= q_job.early ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                default:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                        if (job_reg.is_update && !job_reg.early)
                        begin
                            for (int t = 0; t < NUM_TABLES; t++)
                            begin
                                if (job_reg.tsel == 3'(t))
                                begin
                                    if (job_reg.remove && found_reg)
                                    begin
                                        valid_reg[t][found_idx_reg] <= 1'b0;
                                    end
                                    else if (mem_wr)
                                    begin
                                        valid_reg[t][free_idx_reg] <= 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end
endmodule

>>> sv/ipv4bf_top_note.sv
// Byte count step for the front part of the filter: advances the count and holds it at 63.
// No dependencies.
module ipv4bf_len_sat (
    input  logic [5:0] idx,
    output logic [5:0] len
);
    assign len = (idx == 6'd63) ? 6'd63 : idx + 6'd1;
endmodule

>>> sv/ipv4_blacklist_packet_filter.sv
// Top level of the IPv4 blacklist packet filter.
// Instantiates ipv4bf_front, ipv4bf_queue and ipv4bf_back; depends on ipv4bf_pkg.
//
// Frame bytes are taken one per cycle while the two-entry job queue has room; every beat
// waits while it is full. Each update and each final frame byte becomes one job in that
// queue. A frame rejected on length or ethertype, and an update naming a table that does
// not exist, skips the table scan in the back part. Any other job is scanned through all
// TABLE_ENTRIES slots: the back part reads one slot of every table per cycle through the
// single read port of each key memory and compares all six tables at once. The result
// register lets the next job start while a result waits to be popped. The tables are
// empty after reset with no clearing pass.
module ipv4_blacklist_packet_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  ipv4bf_pkg::in_item_t  item,
    output logic                  empty,
    input  logic                  pop,
    output ipv4bf_pkg::result_t   result
);
    import ipv4bf_pkg::*;

    logic  accept;
    logic  job_push;
    job_t  job;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    job_t  q_job;

    assign full = q_full;
    assign accept = push && !q_full;

    ipv4bf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (job)
    );

    ipv4bf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_job)
    );

    ipv4bf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );
endmodule
